### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file rsfa_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define ASSERT_COMB(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define ASSERT_SEQ(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rsfa_pkg.sv
`default_nettype none
package rsfa_pkg;

    localparam int NUM_TYPES        = 6;
    localparam int NUM_WIDTHS       = 5;
    localparam int MAX_NEIGHBORS    = 1024;
    localparam int FUNC_TABLE_DEPTH = 1024;

    localparam int ACC_DEPTH = NUM_TYPES * NUM_WIDTHS;
    localparam int ACC_AW    = $clog2(ACC_DEPTH);
    localparam int RUN_W     = $clog2(MAX_NEIGHBORS + 1);
    localparam int PHASE_W   = $clog2(FUNC_TABLE_DEPTH);

    localparam int COORD_W = 24;
    localparam int CUT_W   = 16;
    localparam int SUM_W   = 26;
    localparam int TYPE_W  = 3;
    localparam int WIDX_W  = 3;

    localparam int COS_TERMS = 7;
    localparam int EXP_TERMS = 12;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_CUTOFF   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] neighbor_x;
        logic signed [COORD_W-1:0] neighbor_y;
        logic signed [COORD_W-1:0] neighbor_z;
        logic [TYPE_W-1:0]         neighbor_type;
        logic                      present;
        logic                      last_neighbor;
    } t_in_item;

    typedef struct packed {
        logic [TYPE_W-1:0] type_index;
        logic [WIDX_W-1:0] width_index;
        logic [SUM_W-1:0]  feature_sum;
        logic              last_of_run;
    } t_out_item;

    typedef struct packed {
        t_reg_idx             index;
        logic [COORD_W-1:0]   value;
    } t_cfg_item;

    // Divisors of the cosine series are (2k-1)(2k); the exponential series divides by k.
    localparam logic [7:0] COS_DIV [COS_TERMS] = '{
        8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182
    };

    // Reciprocals scaled by 2^32, rounded down; one correction step follows.
    localparam logic [31:0] COS_RECIP [COS_TERMS] = '{
        32'(64'h1_0000_0000 / 64'd2),
        32'(64'h1_0000_0000 / 64'd12),
        32'(64'h1_0000_0000 / 64'd30),
        32'(64'h1_0000_0000 / 64'd56),
        32'(64'h1_0000_0000 / 64'd90),
        32'(64'h1_0000_0000 / 64'd132),
        32'(64'h1_0000_0000 / 64'd182)
    };

    localparam logic [31:0] EXP_RECIP [EXP_TERMS] = '{
        32'hFFFF_FFFF,
        32'(64'h1_0000_0000 / 64'd2),
        32'(64'h1_0000_0000 / 64'd3),
        32'(64'h1_0000_0000 / 64'd4),
        32'(64'h1_0000_0000 / 64'd5),
        32'(64'h1_0000_0000 / 64'd6),
        32'(64'h1_0000_0000 / 64'd7),
        32'(64'h1_0000_0000 / 64'd8),
        32'(64'h1_0000_0000 / 64'd9),
        32'(64'h1_0000_0000 / 64'd10),
        32'(64'h1_0000_0000 / 64'd11),
        32'(64'h1_0000_0000 / 64'd12)
    };

endpackage
`default_nettype wire

### hw/rtl/rsfa_ifs.sv
`default_nettype none
interface rsfa_in_if;
    import rsfa_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rsfa_out_if;
    import rsfa_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rsfa_cfg_if;
    import rsfa_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/rsfa_ram.sv
`default_nettype none
module rsfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hw/rtl/radial_symmetry_function_accum_top.sv
// Channel | Direction | Carries
// i_in    | sink      | one neighbor request: coordinates, type, present, last flag
// o_out   | source    | one feature sum with its type and width index
// i_cfg   | sink      | one register write: index and data, always ready
//
// A neighbor inside the cutoff runs all of its products through the one shared 32x32 multiplier;
// a width whose exponential underflows skips its series and squaring steps and goes to S_EF.
// A skipped neighbor is taken in S_IDLE; one outside the cutoff passes S_CUT2 to S_CMP, then S_FIN.
// A closing request then sends 30 results, each read in S_ERD and S_ELD and held in S_EOUT until o_out is ready.
// Reset is synchronous and clears the accumulator valid bits at once, with no clearing pass.
// The input is not ready while a neighbor is processed or results are sent.
`default_nettype none
module radial_symmetry_function_accum_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsfa_in_if.sink     i_in,
    rsfa_out_if.source  o_out,
    rsfa_cfg_if.sink    i_cfg
);
    import rsfa_pkg::*;

    typedef enum logic [26:0] {
        S_IDLE = 27'h0000001,
        S_CUT2 = 27'h0000002,
        S_SQX  = 27'h0000004,
        S_SQY  = 27'h0000008,
        S_SQZ  = 27'h0000010,
        S_CMP  = 27'h0000020,
        S_SQRT = 27'h0000040,
        S_DIV  = 27'h0000080,
        S_CX   = 27'h0000100,
        S_CX2  = 27'h0000200,
        S_CSET = 27'h0000400,
        S_TM   = 27'h0000800,
        S_TD   = 27'h0001000,
        S_TQ   = 27'h0002000,
        S_TC   = 27'h0004000,
        S_SEND = 27'h0008000,
        S_DD   = 27'h0010000,
        S_DDS  = 27'h0020000,
        S_EW   = 27'h0040000,
        S_ESQ  = 27'h0080000,
        S_ESQ2 = 27'h0100000,
        S_EF   = 27'h0200000,
        S_EACC = 27'h0400000,
        S_FIN  = 27'h0800000,
        S_ERD  = 27'h1000000,
        S_ELD  = 27'h2000000,
        S_EOUT = 27'h4000000
    } t_state;

    t_state r_state, n_state;

    logic signed [COORD_W-1:0] r_cx, r_cy, r_cz;
    logic [CUT_W-1:0]          r_cut;
    logic [RUN_W-1:0]          r_run;
    logic [ACC_DEPTH-1:0]      r_acc_vld;

    logic                  r_last;
    logic [TYPE_W-1:0]     r_type;
    logic [COORD_W-1:0]    r_ax, r_ay, r_az;
    logic [31:0]           r_cut2;
    logic [49:0]           r_d2;
    logic [63:0]           r_prod;
    logic [31:0]           r_sv, r_sr;
    logic [3:0]            r_cnt;
    logic [CUT_W:0]        r_rem;
    logic [PHASE_W-1:0]    r_q;
    logic                  r_fold;
    logic [31:0]           r_mulv, r_term, r_num, r_q0, r_dd;
    logic signed [34:0]    r_sum;
    logic [3:0]            r_k;
    logic                  r_cosmode;
    logic [30:0]           r_fc, r_e;
    logic [WIDX_W-1:0]     r_w;
    logic [1:0]            r_sqn;
    logic [ACC_AW-1:0]     r_oidx;
    logic [TYPE_W-1:0]     r_ot;
    logic [WIDX_W-1:0]     r_ow;
    t_out_item             r_out;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    logic signed [COORD_W:0] dx, dy, dz;
    logic [COORD_W:0]        adx, ady, adz;
    logic                    take, go;

    logic [49:0]  d2_full;
    logic [31:0]  bitv;
    logic [32:0]  trial;
    logic [31:0]  n_sv, n_sr;
    logic [CUT_W:0] div_t;
    logic [PHASE_W-1:0] n_q;
    logic           cos_fold;
    logic [PHASE_W-1:0] cos_m;

    logic [7:0]   div_k;
    logic [31:0]  recip_k;
    logic [31:0]  rem_k;
    logic [31:0]  quot_k;
    logic         series_done;
    logic [30:0]  clamped;
    logic [31:0]  half_fc;

    logic [4:0]   y_shift;
    logic [31:0]  y_val;

    logic [ACC_AW-1:0] acc_addr;
    logic [ACC_AW-1:0] ram_raddr;
    logic [SUM_W-1:0]  ram_rdata;
    logic [SUM_W-1:0]  acc_old;
    logic [31:0]       q16;
    logic [SUM_W:0]    acc_sum;
    logic [SUM_W-1:0]  acc_new;
    logic              ram_we;

    function automatic logic [30:0] clamp_q30(input logic signed [34:0] s);
        logic [30:0] res;
        if (s < 0) begin
            res = '0;
        end else if (s > $signed(35'(ONE_Q30))) begin
            res = ONE_Q30;
        end else begin
            res = s[30:0];
        end
        return res;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_EOUT);
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_cut <= CUT_W'(5120);
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                REG_CENTER_X: r_cx  <= i_cfg.data.value;
                REG_CENTER_Y: r_cy  <= i_cfg.data.value;
                REG_CENTER_Z: r_cz  <= i_cfg.data.value;
                REG_CUTOFF:   r_cut <= i_cfg.data.value[CUT_W-1:0];
                default: ;
            endcase
        end
    end

    assign dx  = (COORD_W+1)'(i_in.data.neighbor_x) - (COORD_W+1)'(r_cx);
    assign dy  = (COORD_W+1)'(i_in.data.neighbor_y) - (COORD_W+1)'(r_cy);
    assign dz  = (COORD_W+1)'(i_in.data.neighbor_z) - (COORD_W+1)'(r_cz);
    assign adx = dx[COORD_W] ? -dx : dx;
    assign ady = dy[COORD_W] ? -dy : dy;
    assign adz = dz[COORD_W] ? -dz : dz;
    assign take = i_in.data.present && (r_run < RUN_W'(MAX_NEIGHBORS));
    assign go   = take && (int'(i_in.data.neighbor_type) < NUM_TYPES)
                  && !(dx == '0 && dy == '0 && dz == '0);

    assign d2_full = r_d2 + r_prod[49:0];

    assign bitv  = 32'd1 << {r_cnt, 1'b0};
    assign trial = {1'b0, r_sr} + {1'b0, bitv};
    always_comb begin
        if ({1'b0, r_sv} >= trial) begin
            n_sv = r_sv - trial[31:0];
            n_sr = (r_sr >> 1) + bitv;
        end else begin
            n_sv = r_sv;
            n_sr = r_sr >> 1;
        end
    end

    assign div_t = {r_rem[CUT_W-1:0], 1'b0};
    assign n_q   = {r_q[PHASE_W-2:0], (div_t >= {1'b0, r_cut})};

    assign cos_fold = (int'(r_q) > FUNC_TABLE_DEPTH / 2);
    assign cos_m    = cos_fold ? PHASE_W'(FUNC_TABLE_DEPTH - int'(r_q)) : r_q;

    assign div_k   = r_cosmode ? COS_DIV[r_k[2:0]] : (8'(r_k) + 8'd1);
    assign recip_k = r_cosmode ? COS_RECIP[r_k[2:0]] : EXP_RECIP[r_k];
    assign rem_k   = r_num - r_prod[31:0];
    assign quot_k  = (rem_k >= 32'(div_k)) ? r_q0 + 32'd1 : r_q0;
    assign series_done = r_cosmode ? (int'(r_k) == COS_TERMS - 1)
                                   : (int'(r_k) == EXP_TERMS - 1);
    assign clamped = clamp_q30(r_sum);
    assign half_fc = (32'(ONE_Q30) + 32'(clamped)) >> 1;

    assign y_shift = 5'({r_w, 1'b0}) + 5'd2;
    assign y_val   = r_dd >> y_shift;

    assign acc_addr  = ACC_AW'(int'(r_type) * NUM_WIDTHS + int'(r_w));
    assign ram_raddr = (r_state == S_EF) ? acc_addr : r_oidx;
    assign acc_old   = r_acc_vld[acc_addr] ? ram_rdata : '0;
    assign q16       = (32'(r_prod[60:30]) + 32'd8192) >> 14;
    assign acc_sum   = {1'b0, acc_old} + (SUM_W+1)'(q16);
    assign acc_new   = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
    assign ram_we    = (r_state == S_EACC);

    rsfa_ram #(
        .WIDTH (SUM_W),
        .DEPTH (ACC_DEPTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (acc_addr),
        .i_wdata (acc_new),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_CUT2: begin
                mul_a = 32'(r_cut);
                mul_b = 32'(r_cut);
            end
            S_SQX: begin
                mul_a = 32'(r_ax);
                mul_b = 32'(r_ax);
            end
            S_SQY: begin
                mul_a = 32'(r_ay);
                mul_b = 32'(r_ay);
            end
            S_SQZ: begin
                mul_a = 32'(r_az);
                mul_b = 32'(r_az);
            end
            S_CX: begin
                mul_a = PI_Q30;
                mul_b = 32'(cos_m);
            end
            S_CX2: begin
                mul_a = r_prod[PHASE_W +: 32];
                mul_b = r_prod[PHASE_W +: 32];
            end
            S_TM: begin
                mul_a = r_term;
                mul_b = r_mulv;
            end
            S_TD: begin
                mul_a = r_prod[61:30];
                mul_b = recip_k;
            end
            S_TQ: begin
                mul_a = r_prod[63:32];
                mul_b = 32'(div_k);
            end
            S_DD: begin
                mul_a = 32'(r_sr[15:0]);
                mul_b = 32'(r_sr[15:0]);
            end
            S_ESQ: begin
                mul_a = 32'(r_e);
                mul_b = 32'(r_e);
            end
            S_EF: begin
                mul_a = 32'(r_e);
                mul_b = 32'(r_fc);
            end
            default: ;
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (go) begin
                        n_state = S_CUT2;
                    end else if (i_in.data.last_neighbor) begin
                        n_state = S_ERD;
                    end
                end
            end
            S_CUT2: n_state = S_SQX;
            S_SQX:  n_state = S_SQY;
            S_SQY:  n_state = S_SQZ;
            S_SQZ:  n_state = S_CMP;
            S_CMP:  n_state = (d2_full >= 50'(r_cut2)) ? S_FIN : S_SQRT;
            S_SQRT: n_state = (r_cnt == '0) ? S_DIV : S_SQRT;
            S_DIV:  n_state = (r_cnt == '0) ? S_CX : S_DIV;
            S_CX:   n_state = S_CX2;
            S_CX2:  n_state = S_CSET;
            S_CSET: n_state = S_TM;
            S_TM:   n_state = S_TD;
            S_TD:   n_state = S_TQ;
            S_TQ:   n_state = S_TC;
            S_TC:   n_state = series_done ? S_SEND : S_TM;
            S_SEND: n_state = r_cosmode ? S_DD : S_ESQ;
            S_DD:   n_state = S_DDS;
            S_DDS:  n_state = S_EW;
            S_EW:   n_state = (|y_val[31:20]) ? S_EF : S_TM;
            S_ESQ:  n_state = S_ESQ2;
            S_ESQ2: n_state = (r_sqn == 2'd3) ? S_EF : S_ESQ;
            S_EF:   n_state = S_EACC;
            S_EACC: n_state = (int'(r_w) == NUM_WIDTHS - 1) ? S_FIN : S_EW;
            S_FIN:  n_state = r_last ? S_ERD : S_IDLE;
            S_ERD:  n_state = S_ELD;
            S_ELD:  n_state = S_EOUT;
            S_EOUT: begin
                if (o_out.ready) begin
                    n_state = (int'(r_oidx) == ACC_DEPTH - 1) ? S_IDLE : S_ERD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_run     <= '0;
            r_acc_vld <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_in.valid && take) begin
                r_run <= r_run + RUN_W'(1);
            end
            if (r_state == S_EACC) begin
                r_acc_vld[acc_addr] <= 1'b1;
            end
            if (r_state == S_EOUT && o_out.ready) begin
                r_acc_vld[r_oidx] <= 1'b0;
                if (int'(r_oidx) == ACC_DEPTH - 1) begin
                    r_run <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            S_IDLE: begin
                r_last <= i_in.data.last_neighbor;
                r_type <= i_in.data.neighbor_type;
                r_ax   <= adx[COORD_W-1:0];
                r_ay   <= ady[COORD_W-1:0];
                r_az   <= adz[COORD_W-1:0];
                r_oidx <= '0;
                r_ot   <= '0;
                r_ow   <= '0;
            end
            S_SQX: r_cut2 <= r_prod[31:0];
            S_SQY: r_d2   <= r_prod[49:0];
            S_SQZ: r_d2   <= d2_full;
            S_CMP: begin
                r_sv  <= d2_full[31:0];
                r_sr  <= '0;
                r_cnt <= 4'd15;
            end
            S_SQRT: begin
                r_sv  <= n_sv;
                r_sr  <= n_sr;
                if (r_cnt == '0) begin
                    r_rem <= (CUT_W+1)'(n_sr[CUT_W-1:0]);
                    r_q   <= '0;
                    r_cnt <= 4'(PHASE_W - 1);
                end else begin
                    r_cnt <= r_cnt - 4'd1;
                end
            end
            S_DIV: begin
                r_q   <= n_q;
                r_rem <= n_q[0] ? div_t - {1'b0, r_cut} : div_t;
                r_cnt <= r_cnt - 4'd1;
            end
            S_CX: r_fold <= cos_fold;
            S_CSET: begin
                r_mulv    <= r_prod[61:30];
                r_term    <= 32'(ONE_Q30);
                r_sum     <= 35'(ONE_Q30);
                r_k       <= '0;
                r_cosmode <= 1'b1;
            end
            S_TD: r_num <= r_prod[61:30];
            S_TQ: r_q0  <= r_prod[63:32];
            S_TC: begin
                r_term <= quot_k;
                r_sum  <= r_k[0] ? r_sum + $signed(35'(quot_k))
                                 : r_sum - $signed(35'(quot_k));
                r_k    <= r_k + 4'd1;
            end
            S_SEND: begin
                if (r_cosmode) begin
                    r_fc <= r_fold ? ONE_Q30 - half_fc[30:0] : half_fc[30:0];
                end else begin
                    r_e   <= clamped;
                    r_sqn <= '0;
                end
            end
            S_DDS: begin
                r_dd <= r_prod[31:0];
                r_w  <= '0;
            end
            S_EW: begin
                if (|y_val[31:20]) begin
                    r_e <= '0;
                end else begin
                    r_mulv    <= {2'b00, y_val[19:0], 10'b0};
                    r_term    <= 32'(ONE_Q30);
                    r_sum     <= 35'(ONE_Q30);
                    r_k       <= '0;
                    r_cosmode <= 1'b0;
                end
            end
            S_ESQ2: begin
                r_e   <= r_prod[60:30];
                r_sqn <= r_sqn + 2'd1;
            end
            S_EACC: r_w <= r_w + WIDX_W'(1);
            S_ELD: begin
                r_out.type_index  <= r_ot;
                r_out.width_index <= r_ow;
                r_out.feature_sum <= r_acc_vld[r_oidx] ? ram_rdata : '0;
                r_out.last_of_run <= (int'(r_oidx) == ACC_DEPTH - 1);
            end
            S_EOUT: begin
                if (o_out.ready) begin
                    r_oidx <= r_oidx + ACC_AW'(1);
                    if (int'(r_ow) == NUM_WIDTHS - 1) begin
                        r_ow <= '0;
                        r_ot <= r_ot + TYPE_W'(1);
                    end else begin
                        r_ow <= r_ow + WIDX_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/rsfa_chk.sv
`default_nettype none
`include "assert_macros.svh"
module rsfa_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input rsfa_pkg::t_out_item i_out_data
);
    import rsfa_pkg::*;

    logic out_stall;
    logic out_take;
    logic out_close;
    logic idx_ok;

    assign out_stall = i_out_valid && !i_out_ready;
    assign out_take  = i_out_valid && i_out_ready;
    assign out_close = out_take && i_out_data.last_of_run;
    assign idx_ok    = (int'(i_out_data.type_index) < NUM_TYPES)
                       && (int'(i_out_data.width_index) < NUM_WIDTHS);

    `ASSERT_SEQ(a_out_hold, out_stall, i_out_valid && $stable(i_out_data), "result changed")
    `ASSERT_COMB(a_busy_emit, i_out_valid, !i_in_ready, "input ready while results are sent")
    `ASSERT_SEQ(a_read_gap, out_take && !out_close, !i_out_valid, "no read gap after result")
    `ASSERT_COMB(a_idx_range, i_out_valid, idx_ok, "result index out of range")
    `ASSERT_SEQ(a_run_end, out_close, i_in_ready, "block not idle after the final result")

endmodule

bind radial_symmetry_function_accum_top rsfa_chk u_rsfa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import rsfa_pkg::*;

    localparam int DRAIN_CYCLES = 400;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned PI_FIX = 64'd3373259426;
    localparam longint unsigned SUM_TOP = 64'd67108863;

    typedef struct {
        int x;
        int y;
        int z;
        int kind;
        bit present;
        bit last;
        int typed_sum;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rsfa_in_if  in_ch();
    rsfa_out_if out_ch();
    rsfa_cfg_if cfg_ch();

    radial_symmetry_function_accum_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    longint signed ctr_x, ctr_y, ctr_z;
    longint unsigned cut_len;
    longint unsigned sums [NUM_TYPES*NUM_WIDTHS];
    int neighbors_in_run;
    t_out_item pending_sums[$];
    int mismatches = 0;
    int requests_sent = 0;
    int sums_seen = 0;
    int runs_closed = 0;
    bit calm = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 30);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned clamp_one(longint signed s);
        if (s < 0) return 0;
        if (longint'(s) > longint'(Q30_ONE)) return Q30_ONE;
        return s;
    endfunction

    function automatic longint unsigned cosine_fix(longint unsigned m);
        longint unsigned x = (PI_FIX * m) / FUNC_TABLE_DEPTH;
        longint unsigned x2 = (x * x) >> 30;
        longint unsigned term = Q30_ONE;
        longint signed acc = Q30_ONE;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / ((2*k - 1) * (2*k));
            if (k % 2 == 1) acc -= term;
            else acc += term;
        end
        return clamp_one(acc);
    endfunction

    function automatic longint unsigned taper_fix(longint unsigned p);
        if (2*p <= FUNC_TABLE_DEPTH) return (Q30_ONE + cosine_fix(p)) >> 1;
        return Q30_ONE - ((Q30_ONE + cosine_fix(FUNC_TABLE_DEPTH - p)) >> 1);
    endfunction

    function automatic longint unsigned gauss_fix(longint unsigned y);
        longint unsigned v, r;
        longint unsigned term = Q30_ONE;
        longint signed acc = Q30_ONE;
        if (y >= (64'd16 << 16)) return 0;
        v = y << 10;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * v) >> 30) / k;
            if (k % 2 == 1) acc -= term;
            else acc += term;
        end
        r = clamp_one(acc);
        for (int i = 0; i < 4; i++) r = (r * r) >> 30;
        return r;
    endfunction

    function automatic void add_neighbor(t_in_item it);
        longint signed dx, dy, dz;
        longint unsigned d2, d, p, fc, y, q;
        int t;
        dx = longint'(it.neighbor_x) - ctr_x;
        dy = longint'(it.neighbor_y) - ctr_y;
        dz = longint'(it.neighbor_z) - ctr_z;
        t = it.neighbor_type;
        if (t >= NUM_TYPES) return;
        if (dx == 0 && dy == 0 && dz == 0) return;
        d2 = dx*dx + dy*dy + dz*dz;
        if (d2 >= cut_len * cut_len) return;
        d = int_sqrt(d2);
        p = (d * FUNC_TABLE_DEPTH) / cut_len;
        if (p >= FUNC_TABLE_DEPTH) p = FUNC_TABLE_DEPTH - 1;
        fc = taper_fix(p);
        for (int w = 0; w < NUM_WIDTHS; w++) begin
            y = (d * d) >> (2 + 2*w);
            q = (((gauss_fix(y) * fc) >> 30) + 8192) >> 14;
            sums[t*NUM_WIDTHS + w] += q;
            if (sums[t*NUM_WIDTHS + w] > SUM_TOP) sums[t*NUM_WIDTHS + w] = SUM_TOP;
        end
    endfunction

    // A typed value below zero, such as -1, takes the computed sums, any other value replaces them.
    function automatic void predict_features(t_in_item it, int typed_sum);
        t_out_item o;
        if (it.present && neighbors_in_run < MAX_NEIGHBORS) begin
            neighbors_in_run++;
            add_neighbor(it);
        end
        if (!it.last_neighbor) return;
        for (int t = 0; t < NUM_TYPES; t++) begin
            for (int w = 0; w < NUM_WIDTHS; w++) begin
                o.type_index = TYPE_W'(t);
                o.width_index = WIDX_W'(w);
                o.feature_sum = (typed_sum < 0) ? SUM_W'(sums[t*NUM_WIDTHS + w])
                                                : SUM_W'(typed_sum);
                o.last_of_run = (t*NUM_WIDTHS + w == NUM_TYPES*NUM_WIDTHS - 1);
                pending_sums = {pending_sums, o};
                sums[t*NUM_WIDTHS + w] = 0;
            end
        end
        neighbors_in_run = 0;
    endfunction

    task automatic send_neighbor(t_in_item it, int typed_sum);
        while (idle_now()) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_features(it, typed_sum);
        requests_sent++;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [COORD_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.value <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_CENTER_X: ctr_x = longint'(signed'(v));
            REG_CENTER_Y: ctr_y = longint'(signed'(v));
            REG_CENTER_Z: ctr_z = longint'(signed'(v));
            REG_CUTOFF:   cut_len = v[CUT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_center(int x, int y, int z, int c);
        write_reg(REG_CENTER_X, x[23:0]);
        write_reg(REG_CENTER_Y, y[23:0]);
        write_reg(REG_CENTER_Z, z[23:0]);
        write_reg(REG_CUTOFF, {8'd0, c[15:0]});
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic int near_coord(longint signed c, int span);
        longint signed v = c + $urandom_range(0, 2*span) - span;
        return int'(v);
    endfunction

    task automatic random_run_set(int count);
        t_in_item it;
        int span;
        for (int i = 0; i < count; i++) begin
            span = (cut_len * 3) / 5 + 1;
            if ($urandom_range(99) < 12) begin
                it.neighbor_x = $urandom;
                it.neighbor_y = $urandom;
                it.neighbor_z = $urandom;
            end else begin
                it.neighbor_x = near_coord(ctr_x, span);
                it.neighbor_y = near_coord(ctr_y, span);
                it.neighbor_z = near_coord(ctr_z, span);
            end
            it.neighbor_type = ($urandom_range(99) < 85) ? $urandom_range(NUM_TYPES-1)
                                                         : $urandom_range(7);
            it.present = ($urandom_range(99) < 90);
            it.last_neighbor = (i == count - 1) || ($urandom_range(99) < 9);
            calm = (requests_sent >= 100 && requests_sent < 160);
            send_neighbor(it, -1);
        end
    endtask

    always @(posedge i_clk) begin
        out_ch.ready <= !idle_now();
    end

    always @(posedge i_clk) begin
        t_out_item exp_o;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sums_seen++;
            if (pending_sums.size() == 0) begin
                $error("unexpected feature sum %p", out_ch.data);
                mismatches++;
            end else begin
                exp_o = pending_sums.pop_front();
                if (out_ch.data.type_index !== exp_o.type_index) begin
                    $error("type_index expected %0d got %0d",
                           exp_o.type_index, out_ch.data.type_index);
                    mismatches++;
                end
                if (out_ch.data.width_index !== exp_o.width_index) begin
                    $error("width_index expected %0d got %0d",
                           exp_o.width_index, out_ch.data.width_index);
                    mismatches++;
                end
                if (out_ch.data.feature_sum !== exp_o.feature_sum) begin
                    $error("feature_sum expected %0d got %0d",
                           exp_o.feature_sum, out_ch.data.feature_sum);
                    mismatches++;
                end
                if (out_ch.data.last_of_run !== exp_o.last_of_run) begin
                    $error("last_of_run expected %0d got %0d",
                           exp_o.last_of_run, out_ch.data.last_of_run);
                    mismatches++;
                end
                if (exp_o.last_of_run) runs_closed++;
            end
        end
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_in_item it;
        rows = '{
            '{0, 0, 0, 0, 0, 1, 0},
            '{0, 0, 0, 0, 1, 1, 0},
            '{256, 0, 0, 0, 1, 0, -1},
            '{0, -256, 0, 1, 1, 0, -1},
            '{0, 0, 5119, 2, 1, 0, -1},
            '{5120, 0, 0, 3, 1, 0, -1},
            '{1, 0, 0, 4, 1, 0, -1},
            '{100, 100, 100, 5, 1, 0, -1},
            '{100, 0, 0, 6, 1, 0, -1},
            '{100, 0, 0, 7, 1, 0, -1},
            '{8388607, 8388607, 8388607, 0, 1, 0, -1},
            '{-8388608, -8388608, -8388608, 1, 1, 0, -1},
            '{300, -400, 0, 5, 0, 0, -1},
            '{3000, 3000, 2000, 5, 1, 1, -1},
            '{-2560, 0, 0, 3, 1, 0, -1},
            '{0, 0, 0, 0, 0, 1, -1},
            '{0, 0, 0, 0, 0, 1, 0}
        };
        ctr_x = 0;
        ctr_y = 0;
        ctr_z = 0;
        cut_len = 5120;
        neighbors_in_run = 0;
        foreach (sums[i]) sums[i] = 0;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            it.neighbor_x = rows[i].x[23:0];
            it.neighbor_y = rows[i].y[23:0];
            it.neighbor_z = rows[i].z[23:0];
            it.neighbor_type = rows[i].kind[2:0];
            it.present = rows[i].present;
            it.last_neighbor = rows[i].last;
            send_neighbor(it, rows[i].typed_sum);
        end
        drain();

        set_center(0, 0, 0, 0);
        random_run_set(10);
        drain();
        set_center(8388607, -8388608, 12345, 1);
        random_run_set(10);
        drain();
        set_center($urandom, $urandom, $urandom, 65535);
        random_run_set(110);
        drain();
        set_center($urandom, $urandom, $urandom, $urandom_range(256, 8000));
        random_run_set(110);
        drain();
        set_center(-8388608, 8388607, -8388608, $urandom_range(1, 65535));
        random_run_set(110);
        drain();

        if (pending_sums.size() != 0) mismatches++;
        $display("Covered %0d neighbor requests and %0d feature sums over %0d runs,",
                 requests_sent, sums_seen, runs_closed);
        $display("with cutoffs from 0 to 65535 and extreme centers.");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
